// ----- rtl/core/dre_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dre_pkg: shared definitions for the 2D draw engine
// Screen geometry, register offsets, command codes, engine modes and the
// structures passed between the register file and the draw sequencer.
// ============================================================================
package dre_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    localparam int DATA_W     = 32;
    localparam int OFFSET_W   = 3;
    localparam int COORD_W    = 10;
    localparam int CURSOR_W   = 11;
    localparam int ERR_W      = 13;
    localparam int COLOR_W    = 12;
    localparam int CMD_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int PIX_ADDR_W = 19;

    // Wide enough for an 11-bit row times the width plus an 11-bit column.
    localparam int PROD_W = CURSOR_W + $clog2(SCREEN_WIDTH + 1) + 1;

    localparam int CLEAR_TOTAL = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int CLEAR_W     = $clog2(CLEAR_TOTAL + 1);

    // Control register fields.
    localparam int CTRL_START_BIT = 4;

    // Interrupt status bits.
    localparam int IRQ_DONE_BIT  = 0;
    localparam int IRQ_VSYNC_BIT = 1;

    // Register word offsets.
    localparam logic [OFFSET_W-1:0] REG_STATUS   = 3'd0;
    localparam logic [OFFSET_W-1:0] REG_CONTROL  = 3'd1;
    localparam logic [OFFSET_W-1:0] REG_COORD0   = 3'd2;
    localparam logic [OFFSET_W-1:0] REG_COORD1   = 3'd3;
    localparam logic [OFFSET_W-1:0] REG_COLOR    = 3'd4;
    localparam logic [OFFSET_W-1:0] REG_INT_STAT = 3'd5;
    localparam logic [OFFSET_W-1:0] REG_INT_EN   = 3'd6;

    // Command codes in control bits 3..0.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 4'd1;
    localparam logic [CMD_W-1:0] CMD_RECT  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_LINE  = 4'd3;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_VSYNC = 2'd2,
        OP_STEP  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_RECT  = 2'd2,
        MODE_LINE  = 2'd3
    } mode_t;

    typedef struct packed {
        opcode_t               op;
        logic [OFFSET_W-1:0]   offset;
        logic [DATA_W-1:0]     data;
    } item_t;

    // Command request from the register file, with the operands it latches.
    typedef struct packed {
        logic                request;
        logic [CMD_W-1:0]    cmd;
        logic [COORD_W-1:0]  x0;
        logic [COORD_W-1:0]  y0;
        logic [COORD_W-1:0]  a;
        logic [COORD_W-1:0]  b;
        logic [COLOR_W-1:0]  color;
    } cmd_req_t;

    // Sequencer status back to the register file.
    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;

    typedef struct packed {
        logic                  valid;
        logic [PIX_ADDR_W-1:0] address;
        logic [COLOR_W-1:0]    color;
    } pixel_t;

endpackage
`default_nettype wire

// ----- rtl/core/register_mapped_2d_draw_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// register_mapped_2d_draw_engine: register-mapped 2D draw engine
// Host register file plus a clear / rectangle / line sequencer that emits
// at most one frame-buffer pixel write per draw step.
// ============================================================================
// Each input transaction is a register read, a register write, a vsync tick
// or a draw step tick, and each one produces exactly one registered result
// transaction, carrying the read data, the irq level, an optional pixel
// write (y times the screen width plus x, 12-bit colour) and the busy flag.
// The block takes one transaction per clock unless stalled: all the work of a
// transaction, the register update, the Bresenham or rectangle step and the
// pixel address multiply by the constant screen width, is done between the
// engine state and the result register. The result register sits between the
// two sides, so a new transaction is taken while the previous result is
// still waiting, and input is stalled only when that result is held by a
// stall on the output. A command starts on a write to control with bit 4 set
// while the engine is idle; its coordinates and colour are latched then, and
// later writes to those registers do not disturb it. A start while busy only
// updates the control register. Unknown commands and empty rectangles finish
// at once and set the done status bit. A clear takes one step per screen
// pixel, a rectangle one step per candidate pixel inside its bounds, and a
// line one step per point from start to end inclusive; off-screen candidates
// use up their step without a pixel write. Interrupt status is
// write-one-to-clear, and irq is high while any enabled status bit is set.
// ============================================================================
module register_mapped_2d_draw_engine import dre_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            opcode,
    input  wire logic [OFFSET_W-1:0]   reg_offset,
    input  wire logic [DATA_W-1:0]     write_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [DATA_W-1:0]          read_data,
    output logic                       irq,
    output logic                       pixel_valid,
    output logic [PIX_ADDR_W-1:0]      pixel_address,
    output logic [COLOR_W-1:0]         pixel_color,
    output logic                       busy_res
);

    item_t        item;
    logic         fire;
    cmd_req_t     cmd_req;
    eng_status_t  eng_status;
    pixel_t       pixel;
    logic         busy_next;
    logic [DATA_W-1:0] rd_data;
    logic         irq_next;

    logic                   out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]      read_data_reg;
    logic                   irq_reg;
    logic                   pixel_valid_reg;
    logic [PIX_ADDR_W-1:0]  pixel_address_reg;
    logic [COLOR_W-1:0]     pixel_color_reg;
    logic                   busy_res_reg;

    // Input is held off only while an unaccepted result occupies the register.
    assign in_stall = out_valid_reg && out_stall;
    assign fire     = in_valid && !in_stall;

    assign item.op     = opcode_t'(opcode);
    assign item.offset = reg_offset;
    assign item.data   = write_data;

    dre_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .status    (eng_status),
        .cmd_req   (cmd_req),
        .read_data (rd_data),
        .irq       (irq_next)
    );

    dre_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .cmd_req   (cmd_req),
        .status    (eng_status),
        .pixel     (pixel),
        .busy_next (busy_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The result payload loads only with a new transaction, so it holds
    // steady while the output is stalled.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_data_reg     <= rd_data;
            irq_reg           <= irq_next;
            pixel_valid_reg   <= pixel.valid;
            pixel_address_reg <= pixel.address;
            pixel_color_reg   <= pixel.color;
            busy_res_reg      <= busy_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign irq           = irq_reg;
    assign pixel_valid   = pixel_valid_reg;
    assign pixel_address = pixel_address_reg;
    assign pixel_color   = pixel_color_reg;
    assign busy_res      = busy_res_reg;

endmodule
`default_nettype wire

// ----- rtl/core/dre_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dre_regs: host register file
// Control, coordinate, colour and interrupt registers, read mux and irq.
// ============================================================================
module dre_regs import dre_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire item_t             item,
    input  wire eng_status_t       status,
    output cmd_req_t               cmd_req,
    output logic [DATA_W-1:0]      read_data,
    output logic                   irq
);

    logic [DATA_W-1:0]   control_reg, control_next;
    logic [DATA_W-1:0]   coord0_reg, coord0_next;
    logic [DATA_W-1:0]   coord1_reg, coord1_next;
    logic [DATA_W-1:0]   color_reg, color_next;
    logic [STATUS_W-1:0] int_stat_reg, int_stat_next;
    logic [DATA_W-1:0]   int_en_reg, int_en_next;

    logic is_write;

    assign is_write = fire && (item.op == OP_WRITE);

    always_comb
    begin
        control_next  = control_reg;
        coord0_next   = coord0_reg;
        coord1_next   = coord1_reg;
        color_next    = color_reg;
        int_stat_next = int_stat_reg;
        int_en_next   = int_en_reg;
        if (is_write)
        begin
            case (item.offset)
                REG_CONTROL:  control_next = item.data;
                REG_COORD0:   coord0_next  = item.data;
                REG_COORD1:   coord1_next  = item.data;
                REG_COLOR:    color_next   = item.data;
                REG_INT_STAT: int_stat_next = int_stat_reg & ~item.data[STATUS_W-1:0];
                REG_INT_EN:   int_en_next  = item.data;
                default:      ;
            endcase
        end
        if (fire && (item.op == OP_VSYNC))
        begin
            int_stat_next[IRQ_VSYNC_BIT] = 1'b1;
        end
        if (status.done)
        begin
            int_stat_next[IRQ_DONE_BIT] = 1'b1;
        end
    end

    // The sequencer decides whether the engine is free to take the command.
    always_comb
    begin
        cmd_req.request = is_write && (item.offset == REG_CONTROL)
                          && item.data[CTRL_START_BIT];
        cmd_req.cmd     = item.data[CMD_W-1:0];
        cmd_req.x0      = coord0_reg[COORD_W-1:0];
        cmd_req.y0      = coord0_reg[16 +: COORD_W];
        cmd_req.a       = coord1_reg[COORD_W-1:0];
        cmd_req.b       = coord1_reg[16 +: COORD_W];
        cmd_req.color   = color_reg[COLOR_W-1:0];
    end

    always_comb
    begin
        read_data = '0;
        if (fire && (item.op == OP_READ))
        begin
            case (item.offset)
                REG_STATUS:   read_data = {{(DATA_W-1){1'b0}}, status.busy};
                REG_CONTROL:  read_data = control_reg;
                REG_COORD0:   read_data = coord0_reg;
                REG_COORD1:   read_data = coord1_reg;
                REG_COLOR:    read_data = color_reg;
                REG_INT_STAT: read_data = {{(DATA_W-STATUS_W){1'b0}}, int_stat_reg};
                REG_INT_EN:   read_data = int_en_reg;
                default:      read_data = '0;
            endcase
        end
    end

    // The interrupt line reflects the state after this transaction.
    assign irq = |(int_stat_next & int_en_next[STATUS_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= '0;
            coord0_reg   <= '0;
            coord1_reg   <= '0;
            color_reg    <= '0;
            int_stat_reg <= '0;
            int_en_reg   <= '0;
        end
        else
        begin
            control_reg  <= control_next;
            coord0_reg   <= coord0_next;
            coord1_reg   <= coord1_next;
            color_reg    <= color_next;
            int_stat_reg <= int_stat_next;
            int_en_reg   <= int_en_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/dre_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dre_engine: draw sequencer
// Clear, clipped rectangle fill and clipped Bresenham line, one candidate
// pixel per step transaction.
// ============================================================================
module dre_engine import dre_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire item_t       item,
    input  wire cmd_req_t    cmd_req,
    output eng_status_t      status,
    output pixel_t           pixel,
    output logic             busy_next
);

    mode_t                       mode_reg, mode_next;
    logic [CURSOR_W-1:0]         cursor_x_reg, cursor_x_next;
    logic [CURSOR_W-1:0]         cursor_y_reg, cursor_y_next;
    logic [COORD_W-1:0]          row_start_x_reg, row_start_x_next;
    logic [CURSOR_W-1:0]         end_x_reg, end_x_next;
    logic [CURSOR_W-1:0]         end_y_reg, end_y_next;
    logic [CURSOR_W-1:0]         delta_x_reg, delta_x_next;
    logic [CURSOR_W-1:0]         delta_y_reg, delta_y_next;
    logic                        step_x_neg_reg, step_x_neg_next;
    logic                        step_y_neg_reg, step_y_neg_next;
    logic signed [ERR_W-1:0]     error_reg, error_next;
    logic [COLOR_W-1:0]          draw_color_reg, draw_color_next;
    logic [CLEAR_W-1:0]          clear_index_reg, clear_index_next;

    logic                        done;
    logic                        on_screen;
    logic [PROD_W-1:0]           cursor_addr;
    logic [CURSOR_W-1:0]         x_inc;
    logic [CURSOR_W-1:0]         y_inc;
    logic [CLEAR_W-1:0]          clear_inc;
    logic signed [ERR_W:0]       e2;
    logic signed [ERR_W:0]       dx_s;
    logic signed [ERR_W:0]       dy_s;
    logic signed [ERR_W:0]       err_work;

    assign on_screen = (cursor_x_reg < CURSOR_W'(SCREEN_WIDTH))
                       && (cursor_y_reg < CURSOR_W'(SCREEN_HEIGHT));
    assign cursor_addr = PROD_W'(cursor_y_reg) * PROD_W'(SCREEN_WIDTH)
                         + PROD_W'(cursor_x_reg);
    assign x_inc     = cursor_x_reg + 1'b1;
    assign y_inc     = cursor_y_reg + 1'b1;
    assign clear_inc = clear_index_reg + 1'b1;
    assign e2        = {error_reg, 1'b0};
    assign dx_s      = signed'((ERR_W+1)'(delta_x_reg));
    assign dy_s      = signed'((ERR_W+1)'(delta_y_reg));

    always_comb
    begin
        mode_next        = mode_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        row_start_x_next = row_start_x_reg;
        end_x_next       = end_x_reg;
        end_y_next       = end_y_reg;
        delta_x_next     = delta_x_reg;
        delta_y_next     = delta_y_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        error_next       = error_reg;
        draw_color_next  = draw_color_reg;
        clear_index_next = clear_index_reg;
        done             = 1'b0;
        err_work         = signed'((ERR_W+1)'(error_reg));
        pixel            = '0;

        if (fire && cmd_req.request && (mode_reg == MODE_IDLE))
        begin
            draw_color_next = cmd_req.color;
            case (cmd_req.cmd)
                CMD_CLEAR:
                begin
                    clear_index_next = '0;
                    mode_next        = MODE_CLEAR;
                end
                CMD_RECT:
                begin
                    if ((cmd_req.a == '0) || (cmd_req.b == '0))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        cursor_x_next    = CURSOR_W'(cmd_req.x0);
                        cursor_y_next    = CURSOR_W'(cmd_req.y0);
                        row_start_x_next = cmd_req.x0;
                        end_x_next       = CURSOR_W'(cmd_req.x0) + CURSOR_W'(cmd_req.a);
                        end_y_next       = CURSOR_W'(cmd_req.y0) + CURSOR_W'(cmd_req.b);
                        mode_next        = MODE_RECT;
                    end
                end
                CMD_LINE:
                begin
                    cursor_x_next   = CURSOR_W'(cmd_req.x0);
                    cursor_y_next   = CURSOR_W'(cmd_req.y0);
                    end_x_next      = CURSOR_W'(cmd_req.a);
                    end_y_next      = CURSOR_W'(cmd_req.b);
                    delta_x_next    = (cmd_req.a >= cmd_req.x0)
                                      ? CURSOR_W'(cmd_req.a - cmd_req.x0)
                                      : CURSOR_W'(cmd_req.x0 - cmd_req.a);
                    delta_y_next    = (cmd_req.b >= cmd_req.y0)
                                      ? CURSOR_W'(cmd_req.b - cmd_req.y0)
                                      : CURSOR_W'(cmd_req.y0 - cmd_req.b);
                    step_x_neg_next = !(cmd_req.x0 < cmd_req.a);
                    step_y_neg_next = !(cmd_req.y0 < cmd_req.b);
                    error_next      = signed'(ERR_W'(delta_x_next))
                                      - signed'(ERR_W'(delta_y_next));
                    mode_next       = MODE_LINE;
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
        else if (fire && (item.op == OP_STEP))
        begin
            case (mode_reg)
                MODE_CLEAR:
                begin
                    pixel.valid      = 1'b1;
                    pixel.address    = PIX_ADDR_W'(clear_index_reg);
                    pixel.color      = draw_color_reg;
                    clear_index_next = clear_inc;
                    if (clear_inc >= CLEAR_W'(CLEAR_TOTAL))
                    begin
                        done = 1'b1;
                    end
                end
                MODE_RECT:
                begin
                    if (on_screen)
                    begin
                        pixel.valid   = 1'b1;
                        pixel.address = PIX_ADDR_W'(cursor_addr);
                        pixel.color   = draw_color_reg;
                    end
                    cursor_x_next = x_inc;
                    if (x_inc >= end_x_reg)
                    begin
                        cursor_x_next = CURSOR_W'(row_start_x_reg);
                        cursor_y_next = y_inc;
                        if (y_inc >= end_y_reg)
                        begin
                            done = 1'b1;
                        end
                    end
                end
                MODE_LINE:
                begin
                    if (on_screen)
                    begin
                        pixel.valid   = 1'b1;
                        pixel.address = PIX_ADDR_W'(cursor_addr);
                        pixel.color   = draw_color_reg;
                    end
                    if ((cursor_x_reg == end_x_reg) && (cursor_y_reg == end_y_reg))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        if (e2 >= -dy_s)
                        begin
                            err_work      = err_work - dy_s;
                            cursor_x_next = step_x_neg_reg ? (cursor_x_reg - 1'b1) : x_inc;
                        end
                        if (e2 <= dx_s)
                        begin
                            err_work      = err_work + dx_s;
                            cursor_y_next = step_y_neg_reg ? (cursor_y_reg - 1'b1) : y_inc;
                        end
                        error_next = ERR_W'(err_work);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (done)
        begin
            mode_next = MODE_IDLE;
        end
    end

    assign status.busy = (mode_reg != MODE_IDLE);
    assign status.done = done;
    assign busy_next   = (mode_next != MODE_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            row_start_x_reg <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            delta_x_reg     <= '0;
            delta_y_reg     <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            error_reg       <= '0;
            draw_color_reg  <= '0;
            clear_index_reg <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            row_start_x_reg <= row_start_x_next;
            end_x_reg       <= end_x_next;
            end_y_reg       <= end_y_next;
            delta_x_reg     <= delta_x_next;
            delta_y_reg     <= delta_y_next;
            step_x_neg_reg  <= step_x_neg_next;
            step_y_neg_reg  <= step_y_neg_next;
            error_reg       <= error_next;
            draw_color_reg  <= draw_color_next;
            clear_index_reg <= clear_index_next;
        end
    end

endmodule
`default_nettype wire
